@@ sv/buffer_cache_age_replacement_assert.svh @@
// Assertion macros for the buffer cache age manager.
// Used by buffer_cache_age_replacement; depends on nothing else.
`ifndef BUFFER_CACHE_AGE_REPLACEMENT_ASSERT_SVH
`define BUFFER_CACHE_AGE_REPLACEMENT_ASSERT_SVH

// Assert that cond implies result in the following cycle.
`define BCA_ASSERT_NEXT(label, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

// Assert that cond holds at every enabled edge.
`define BCA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ sv/bca_pkg.sv @@
// Shared types and constants for the buffer cache age manager.
// No dependencies.
`default_nettype none
package bca_pkg;
    localparam int NUM_BUFFERS_DEF = 32;
    localparam int DISK_SIZE_DEF   = 8192;
    localparam int AGE_BITS_DEF    = 16;

    localparam int OPCODE_W = 2;
    localparam int BLOCK_W  = 14;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 5;
    localparam int TAG_W    = 13;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DIRTY = 2'd2,
        OP_FLUSH = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOB  = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BLOCK_W-1:0]  block_num;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  buffer_index;
        logic                writeback_valid;
        logic [INDEX_W-1:0]  writeback_index;
        logic [TAG_W-1:0]    writeback_block;
        logic                last;
    } rsp_t;
endpackage
`default_nettype wire

@@ sv/bca_if.sv @@
// Valid/ready channel interface carrying one item.
// Depends on nothing; payload type is a parameter.
`default_nettype none
interface bca_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/buffer_cache_age_replacement.sv @@
// Top level of the buffer cache age manager: one memory of entry records.
// Depends on bca_pkg, bca_if and buffer_cache_age_replacement_assert.svh.
//
//  channel  dir  payload
//  req      in   opcode, block_num
//  rsp      out  status, buffer_index, writeback_*, last
//
// Every in-bound item reads each entry from the record memory once.
// Alloc, and set-dirty on a hit, then make a second read-modify-write pass.
// A new item is accepted only in idle with the output register empty. Flush emits
// one item per used dirty entry, or one if there is none; the scan stalls while an
// entry to emit meets a full output. Reset clears used bits (flip-flops) at once.
`default_nettype none
`include "buffer_cache_age_replacement_assert.svh"
module buffer_cache_age_replacement #(
    parameter int NUM_BUFFERS = bca_pkg::NUM_BUFFERS_DEF,
    parameter int DISK_SIZE   = bca_pkg::DISK_SIZE_DEF,
    parameter int AGE_BITS    = bca_pkg::AGE_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bca_if.sink      req,
    bca_if.source    rsp
);
    import bca_pkg::*;

    localparam int IW = $clog2(NUM_BUFFERS);
    localparam int CW = IW + 1;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    typedef struct packed {
        logic                dirty;
        logic [AGE_BITS-1:0] age;
        logic [TAG_W-1:0]    tag;
    } rec_t;

    rec_t                   mem [NUM_BUFFERS];
    rec_t                   rd_reg;
    logic [NUM_BUFFERS-1:0] used_reg;

    state_t              state_reg, state_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [TAG_W-1:0]    tag_in_reg;
    logic [CW-1:0]       cnt_reg;
    logic                rd_v_reg;
    logic [IW-1:0]       rd_i_reg;
    logic                hit_reg, free_reg, any_reg;
    logic [IW-1:0]       sel_reg;
    logic [AGE_BITS-1:0] best_age_reg;
    logic                best_dirty_reg;
    logic [TAG_W-1:0]    best_tag_reg;
    rsp_t                out_reg;
    logic                out_v_reg;

    logic acc;
    logic rd_en, wr_en;
    logic [IW-1:0] rd_addr, wr_addr;
    rec_t wr_data;
    logic out_free;
    logic out_load;
    logic emit_flush;
    logic [AGE_BITS-1:0] aged;

    assign acc = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !out_v_reg;
    assign rsp.valid = out_v_reg;
    assign rsp.data = out_reg;
    assign out_free = !out_v_reg || rsp.ready;

    // flush emits while scanning; rd data is stage behind counter
    assign emit_flush = (state_reg == S_SCAN) && (op_reg == OP_FLUSH) && rd_v_reg
                        && used_reg[rd_i_reg] && rd_reg.dirty;

    assign out_load = (emit_flush && out_free && any_reg)
                      || (state_reg == S_OUT && out_free);

    always_comb
    begin
        rd_en = 1'b0;
        rd_addr = cnt_reg[IW-1:0];
        if (state_reg == S_SCAN && cnt_reg < CW'(NUM_BUFFERS) && (!emit_flush || out_free))
            rd_en = 1'b1;
        else if (state_reg == S_WRITE && cnt_reg < CW'(NUM_BUFFERS))
            rd_en = 1'b1;
    end

    always_comb
    begin
        aged = (rd_reg.age < AGE_MAX) ? rd_reg.age + 1'b1 : rd_reg.age;
        wr_en = 1'b0;
        wr_addr = rd_i_reg;
        wr_data = rd_reg;
        if (state_reg == S_WRITE && rd_v_reg)
        begin
            if (op_reg == OP_ALLOC)
            begin
                wr_en = 1'b1;
                if (rd_i_reg == sel_reg)
                    wr_data = '{dirty: 1'b0, age: '0, tag: tag_in_reg};
                else if (used_reg[rd_i_reg])
                    wr_data.age = aged;
                else
                    wr_en = 1'b0;
            end
            else
            begin
                wr_en = (rd_i_reg == sel_reg);
                wr_data.dirty = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_reg <= mem[rd_addr];
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (acc)
                begin
                    if (req.data.opcode != OP_FLUSH
                        && {1'b0, req.data.block_num} >= 15'(DISK_SIZE))
                        state_next = S_OUT;
                    else
                        state_next = S_SCAN;
                end
            S_SCAN:
                if (cnt_reg == CW'(NUM_BUFFERS) && !rd_v_reg && out_free)
                begin
                    if (op_reg == OP_ALLOC || (op_reg == OP_DIRTY && hit_reg))
                        state_next = S_WRITE;
                    else
                        state_next = S_OUT;
                end
            S_WRITE:
                if (cnt_reg == CW'(NUM_BUFFERS) && !rd_v_reg)
                    state_next = S_OUT;
            S_OUT:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            used_reg <= '0;
            rd_v_reg <= 1'b0;
            rd_i_reg <= '0;
            cnt_reg <= '0;
            any_reg <= 1'b0;
            op_reg <= '0;
            tag_in_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            sel_reg <= '0;
            best_age_reg <= '0;
            best_dirty_reg <= 1'b0;
            best_tag_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (acc)
                    begin
                        op_reg <= req.data.opcode;
                        tag_in_reg <= req.data.block_num[TAG_W-1:0];
                        cnt_reg <= '0;
                        rd_v_reg <= 1'b0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        any_reg <= 1'b0;
                        sel_reg <= '0;
                        best_age_reg <= '0;
                        best_dirty_reg <= 1'b0;
                        best_tag_reg <= '0;
                        out_reg <= '{status: ST_OOB, buffer_index: '0, writeback_valid: 1'b0,
                                     writeback_index: '0, writeback_block: '0, last: 1'b1};
                    end
                S_SCAN:
                begin
                    if (state_next != S_SCAN)
                    begin
                        cnt_reg <= '0;
                        rd_v_reg <= 1'b0;
                        if (op_reg == OP_FLUSH)
                            out_reg <= '{status: ST_OK,
                                buffer_index: any_reg ? INDEX_W'(sel_reg) : '0,
                                writeback_valid: any_reg,
                                writeback_index: any_reg ? INDEX_W'(sel_reg) : '0,
                                writeback_block: any_reg ? best_tag_reg : '0, last: 1'b1};
                        else if (op_reg != OP_ALLOC)
                            out_reg <= '{status: hit_reg ? ST_OK : ST_MISS,
                                buffer_index: hit_reg ? INDEX_W'(sel_reg) : '0,
                                writeback_valid: 1'b0, writeback_index: '0,
                                writeback_block: '0, last: 1'b1};
                        else
                            out_reg <= '{status: ST_OK, buffer_index: INDEX_W'(sel_reg),
                                writeback_valid: !free_reg && best_dirty_reg,
                                writeback_index: (!free_reg && best_dirty_reg)
                                                 ? INDEX_W'(sel_reg) : '0,
                                writeback_block: (!free_reg && best_dirty_reg)
                                                 ? best_tag_reg : '0, last: 1'b1};
                    end
                    else if (!emit_flush || out_free)
                    begin
                        rd_v_reg <= rd_en;
                        rd_i_reg <= rd_addr;
                        if (rd_en)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (rd_v_reg && (!emit_flush || out_free))
                    begin
                        if (op_reg == OP_FLUSH)
                        begin
                            if (emit_flush)
                            begin
                                // hold one emitted entry back to know which is last
                                if (any_reg)
                                    out_reg <= '{status: ST_OK,
                                        buffer_index: INDEX_W'(sel_reg), writeback_valid: 1'b1,
                                        writeback_index: INDEX_W'(sel_reg),
                                        writeback_block: best_tag_reg, last: 1'b0};
                                any_reg <= 1'b1;
                                sel_reg <= rd_i_reg;
                                best_tag_reg <= rd_reg.tag;
                            end
                        end
                        else if (op_reg == OP_ALLOC)
                        begin
                            if (!used_reg[rd_i_reg])
                            begin
                                if (!free_reg)
                                begin
                                    free_reg <= 1'b1;
                                    sel_reg <= rd_i_reg;
                                    best_dirty_reg <= 1'b0;
                                end
                            end
                            else if (!free_reg && (!any_reg || aged > best_age_reg))
                            begin
                                any_reg <= 1'b1;
                                sel_reg <= rd_i_reg;
                                best_age_reg <= aged;
                                best_dirty_reg <= rd_reg.dirty;
                                best_tag_reg <= rd_reg.tag;
                            end
                        end
                        else if (!hit_reg && used_reg[rd_i_reg] && rd_reg.tag == tag_in_reg)
                        begin
                            hit_reg <= 1'b1;
                            sel_reg <= rd_i_reg;
                        end
                    end
                end
                S_WRITE:
                begin
                    // reread each entry, then write the modified record
                    rd_v_reg <= rd_en;
                    rd_i_reg <= cnt_reg[IW-1:0];
                    if (rd_en)
                        cnt_reg <= cnt_reg + 1'b1;
                    if (wr_en && op_reg == OP_ALLOC && rd_i_reg == sel_reg)
                        used_reg[sel_reg] <= 1'b1;
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    `BCA_ASSERT_NEXT(a_acc_leaves_idle, acc, state_reg != S_IDLE, "accept did not start work")
    `BCA_ASSERT_ALWAYS(a_ready_idle, !req.ready || state_reg == S_IDLE, "ready outside idle")
    `BCA_ASSERT_NEXT(a_hold_out, out_v_reg && !rsp.ready, out_v_reg && $stable(out_reg),
                     "result dropped under stall")
    `BCA_ASSERT_ALWAYS(a_no_wr_scan, !(wr_en && state_reg == S_SCAN), "write during scan")
endmodule
`default_nettype wire

@@ tb/tb_buffer_cache_age_replacement.sv @@
// Testbench for buffer_cache_age_replacement: a directed table, then random items.
// Responses are checked against a bench model of ages, tags, dirty bits, or a typed row.
// Depends on bca_pkg, bca_if and the RTL of the block.
`default_nettype none
module tb_buffer_cache_age_replacement;
    import bca_pkg::*;

    localparam int NBUF    = NUM_BUFFERS_DEF;
    localparam int DSIZE   = DISK_SIZE_DEF;
    localparam int AGE_TOP = (1 << AGE_BITS_DEF) - 1;
    localparam int N_RAND  = 410;
    localparam int LIMIT   = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bca_if #(.payload_t(req_t)) req ();
    bca_if #(.payload_t(rsp_t)) rsp ();

    buffer_cache_age_replacement uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #4 clk = ~clk;

    typedef struct {
        opcode_t    op;
        logic [13:0] blk;
        bit         typed;
        status_t    st;
        logic [4:0] idx;
    } stim_row_t;

    bit              slot_used [NBUF];
    bit              slot_dirty[NBUF];
    int              slot_age  [NBUF];
    logic [TAG_W-1:0] slot_tag [NBUF];

    rsp_t pending_rsp[$];
    int   errors = 0;
    int   n_items = 0;
    int   n_rsp = 0;
    int   n_evict_wb = 0;
    int   n_flush_wb = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    bit   long_hold = 1'b0;

    function automatic rsp_t make_rsp(status_t st, int idx, bit wv, int widx,
                                      int wblk, bit lst);
        rsp_t r;
        r.status          = st;
        r.buffer_index    = idx[INDEX_W-1:0];
        r.writeback_valid = wv;
        r.writeback_index = widx[INDEX_W-1:0];
        r.writeback_block = wblk[TAG_W-1:0];
        r.last            = lst;
        return r;
    endfunction

    // Updates the cache image and returns the responses the item produces.
    task automatic cache_apply(input opcode_t op, input logic [13:0] blk,
                               output rsp_t res[$]);
        int slot;
        int lastd;
        bit wv;
        int widx;
        int wblk;
        res = {};
        if (op == OP_FLUSH)
        begin
            lastd = -1;
            for (int i = 0; i < NBUF; i++)
                if (slot_used[i] && slot_dirty[i])
                    lastd = i;
            if (lastd < 0)
                res.push_back(make_rsp(ST_OK, 0, 0, 0, 0, 1));
            for (int i = 0; i < NBUF; i++)
                if (slot_used[i] && slot_dirty[i])
                    res.push_back(make_rsp(ST_OK, i, 1, i, int'(slot_tag[i]), i == lastd));
            return;
        end
        if (blk >= DSIZE)
        begin
            res.push_back(make_rsp(ST_OOB, 0, 0, 0, 0, 1));
            return;
        end
        if (op == OP_ALLOC)
        begin
            slot = -1;
            wv = 0;
            widx = 0;
            wblk = 0;
            for (int i = 0; i < NBUF; i++)
                if (slot_used[i] && slot_age[i] < AGE_TOP)
                    slot_age[i]++;
            for (int i = NBUF - 1; i >= 0; i--)
                if (!slot_used[i])
                    slot = i;
            if (slot < 0)
            begin
                slot = 0;
                for (int i = 1; i < NBUF; i++)
                    if (slot_age[i] > slot_age[slot])
                        slot = i;
                if (slot_dirty[slot])
                begin
                    wv = 1;
                    widx = slot;
                    wblk = int'(slot_tag[slot]);
                end
            end
            slot_used[slot]  = 1;
            slot_dirty[slot] = 0;
            slot_age[slot]   = 0;
            slot_tag[slot]   = blk[TAG_W-1:0];
            res.push_back(make_rsp(ST_OK, slot, wv, widx, wblk, 1));
            return;
        end
        slot = -1;
        for (int i = NBUF - 1; i >= 0; i--)
            if (slot_used[i] && slot_tag[i] == blk[TAG_W-1:0])
                slot = i;
        if (slot < 0)
        begin
            res.push_back(make_rsp(ST_MISS, 0, 0, 0, 0, 1));
            return;
        end
        if (op == OP_DIRTY)
            slot_dirty[slot] = 1;
        res.push_back(make_rsp(ST_OK, slot, 0, 0, 0, 1));
    endtask

    task automatic send_item(input opcode_t op, input logic [13:0] blk, input bit typed,
                             input status_t st, input logic [4:0] idx);
        rsp_t res[$];
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data.opcode <= op;
        req.data.block_num <= blk;
        do @(posedge clk); while (!req.ready);
        cache_apply(op, blk, res);
        if (typed)
            pending_rsp.push_back(make_rsp(st, idx, 0, 0, 0, 1));
        else
            foreach (res[k])
            begin
                pending_rsp.push_back(res[k]);
                if (res[k].writeback_valid)
                begin
                    if (op == OP_FLUSH)
                        n_flush_wb++;
                    else
                        n_evict_wb++;
                end
            end
        n_items++;
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Response side
    initial
    begin
        int n;
        rsp_t e;
        rsp.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            n = idle_on ? $urandom_range(0, 10) : 0;
            if (long_hold)
            begin
                n = 400;
                long_hold = 1'b0;
            end
            if (n > 0)
            begin
                rsp.ready <= 1'b0;
                for (int c = 0; c < n; c++) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            n_rsp++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual %p", $time, rsp.data);
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                check_field("status", e.status, rsp.data.status);
                check_field("buffer_index", e.buffer_index, rsp.data.buffer_index);
                check_field("writeback_valid", e.writeback_valid, rsp.data.writeback_valid);
                check_field("writeback_index", e.writeback_index, rsp.data.writeback_index);
                check_field("writeback_block", e.writeback_block, rsp.data.writeback_block);
                check_field("last", e.last, rsp.data.last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    stim_row_t table_rows[] = '{
        '{OP_FLUSH,  14'd0,     1, ST_OK,   5'd0},
        '{OP_LOOKUP, 14'd0,     1, ST_MISS, 5'd0},
        '{OP_DIRTY,  14'd5,     1, ST_MISS, 5'd0},
        '{OP_ALLOC,  14'd8191,  1, ST_OK,   5'd0},
        '{OP_ALLOC,  14'd8192,  1, ST_OOB,  5'd0},
        '{OP_LOOKUP, 14'd16383, 1, ST_OOB,  5'd0},
        '{OP_DIRTY,  14'd16383, 1, ST_OOB,  5'd0},
        '{OP_ALLOC,  14'd0,     1, ST_OK,   5'd1},
        '{OP_ALLOC,  14'd0,     1, ST_OK,   5'd2},
        '{OP_LOOKUP, 14'd0,     1, ST_OK,   5'd1},
        '{OP_DIRTY,  14'd0,     1, ST_OK,   5'd1},
        '{OP_DIRTY,  14'd8191,  1, ST_OK,   5'd0},
        '{OP_LOOKUP, 14'd8191,  1, ST_OK,   5'd0},
        '{OP_FLUSH,  14'd16383, 0, ST_OK,   5'd0},
        '{OP_ALLOC,  14'd4096,  0, ST_OK,   5'd0},
        '{OP_ALLOC,  14'd2730,  0, ST_OK,   5'd0},
        '{OP_ALLOC,  14'd5461,  0, ST_OK,   5'd0},
        '{OP_DIRTY,  14'd2730,  0, ST_OK,   5'd0},
        '{OP_LOOKUP, 14'd10922, 0, ST_OK,   5'd0},
        '{OP_FLUSH,  14'd8192,  0, ST_OK,   5'd0}
    };

    initial
    begin
        int w;
        int wait_n;
        opcode_t op;
        logic [13:0] blk;
        req.valid = 1'b0;
        req.data = '0;
        for (int i = 0; i < NBUF; i++)
        begin
            slot_used[i] = 0;
            slot_dirty[i] = 0;
            slot_age[i] = 0;
            slot_tag[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[r])
            send_item(table_rows[r].op, table_rows[r].blk, table_rows[r].typed,
                      table_rows[r].st, table_rows[r].idx);

        for (int k = 0; k < N_RAND; k++)
        begin
            idle_on = !(k >= 150 && k < 250);
            if (k == 300)
                long_hold = 1'b1;
            if (k == 350)
            begin
                req.valid <= 1'b0;
                while (pending_rsp.size() != 0) @(posedge clk);
            end
            w = $urandom_range(0, 99);
            op = w < 40 ? OP_ALLOC : w < 65 ? OP_LOOKUP : w < 92 ? OP_DIRTY : OP_FLUSH;
            w = $urandom_range(0, 99);
            blk = w < 85 ? 14'($urandom_range(0, 47)) : 14'($urandom_range(0, 16383));
            send_item(op, blk, 0, ST_OK, 5'd0);
        end
        req.valid <= 1'b0;

        wait_n = 0;
        while (pending_rsp.size() != 0 && wait_n < 200000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (200) @(posedge clk);
        if (pending_rsp.size() != 0)
        begin
            $display("%0t: %0d expected items never arrived", $time, pending_rsp.size());
            errors++;
        end
        $display("%0d requests sent, %0d responses checked, %0d errors", n_items, n_rsp,
                 errors);
        $display("writeback items expected: %0d on eviction, %0d from flush",
                 n_evict_wb, n_flush_wb);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ buffer_cache_age_replacement.f @@
+incdir+sv
sv/bca_pkg.sv
sv/bca_if.sv
sv/buffer_cache_age_replacement.sv
tb/tb_buffer_cache_age_replacement.sv
